>>> rtl/imap_clc_pkg.sv
`default_nettype none
package imap_clc_pkg;

   // Line bound; every byte and tag count saturates here.
   localparam int MAX_LINE = 1024;
   localparam int CNT_W    = 11;
   localparam int NUM_KW   = 22;
   localparam int KW_MAX   = 12;
   localparam int POS_W    = 4;
   localparam int CODE_W   = 5;

   localparam logic [CNT_W-1:0]  CNT_MAX        = CNT_W'(MAX_LINE);
   localparam logic [POS_W-1:0]  POS_SAT        = '1;
   localparam logic [NUM_KW-1:0] ALL_CANDIDATES = '1;
   localparam logic [7:0]        SPACE          = 8'h20;
   localparam logic [7:0]        CASE_OFFSET    = 8'h20;

   typedef enum logic [2:0] {
      PH_LEAD = 3'd0,
      PH_TAG  = 3'd1,
      PH_GAP1 = 3'd2,
      PH_WORD = 3'd3,
      PH_GAP2 = 3'd4,
      PH_ARGS = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NO_TAG  = 2'd1,
      ST_UNKNOWN = 2'd2
   } status_type;

   localparam logic [CODE_W-1:0] CODE_UNKNOWN = '0;

   typedef struct packed {
      status_type        status;
      logic [CODE_W-1:0] command_code;
      logic [CNT_W-1:0]  tag_length;
      logic              has_arguments;
      logic [CNT_W-1:0]  argument_offset;
   } result_type;

   // Keyword text, left-aligned, first character in the top byte, zero padded.
   localparam logic [8*KW_MAX-1:0] KW_TEXT [NUM_KW] = '{
      {"noop",         64'd0},
      {"starttls",     32'd0},
      {"select",       48'd0},
      {"status",       48'd0},
      {"store",        56'd0},
      {"subscribe",    24'd0},
      {"authenticate"       },
      {"append",       48'd0},
      {"login",        56'd0},
      {"list",         64'd0},
      {"lsub",         64'd0},
      {"logout",       48'd0},
      {"examine",      40'd0},
      {"create",       48'd0},
      {"check",        56'd0},
      {"close",        56'd0},
      {"copy",         64'd0},
      {"capability",   16'd0},
      {"delete",       48'd0},
      {"unsubscribe",   8'd0},
      {"uid",          72'd0},
      {"fetch",        56'd0}
   };

   localparam logic [POS_W-1:0] KW_LEN [NUM_KW] = '{
      4'd4, 4'd8, 4'd6, 4'd6, 4'd5, 4'd9, 4'd12, 4'd6, 4'd5, 4'd4, 4'd4,
      4'd6, 4'd7, 4'd6, 4'd5, 4'd5, 4'd4, 4'd10, 4'd6, 4'd11, 4'd3, 4'd5
   };

   function automatic logic [7:0] kw_char(input logic [8*KW_MAX-1:0] text,
                                          input logic [POS_W-1:0] pos);
      logic [7:0] ch;
      ch = '0;
      if (int'(pos) < KW_MAX) begin
         ch = text[8*(KW_MAX-1-int'(pos)) +: 8];
      end
      return ch;
   endfunction

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v < CNT_MAX) ? v + CNT_W'(1) : CNT_MAX;
   endfunction

endpackage
`default_nettype wire

>>> rtl/imap_command_line_classifier.sv
// Order: a transferred byte waits in the input register and is parsed as it leaves it;
//   rsp_tvalid rises at the same edge at which the final byte leaves the input register.
// Throughput: one byte per cycle while no final byte waits for room in the result register,
//   set by the single-pass parse between input and result register; one result per line.
// Reset: synchronous, active high; clears both valid flags and the parse state.
`default_nettype none
module imap_command_line_classifier (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] line_byte
   input  wire logic        req_tlast,   // end_of_line
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata    // [1:0] status, [6:2] command_code,
                                         // [17:7] tag_length, [18] has_arguments,
                                         // [29:19] argument_offset, [31:30] zero
);
   import imap_clc_pkg::*;

   // Input register: holds one byte until the parser takes it.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // Result register: holds a finished line summary until the sink takes it.
   logic       out_valid_ff, out_valid_in;
   result_type out_result_ff;

   result_type parse_result;
   logic       req_xfer;
   logic       advance;

   // Bytes that end no line never touch the result register, so they move
   // on even while a result waits; only the final byte waits for room.
   assign advance    = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance && in_last_ff) out_valid_in = 1'b1;
      else if (rsp_tready) out_valid_in = 1'b0;
   end

   imap_clc_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .line_byte   (in_byte_ff),
      .end_of_line (in_last_ff),
      .result      (parse_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload: load on transfer, no reset needed.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && in_last_ff) begin
         out_result_ff <= parse_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00,
                        out_result_ff.argument_offset,
                        out_result_ff.has_arguments,
                        out_result_ff.tag_length,
                        out_result_ff.command_code,
                        out_result_ff.status};

   // A final byte that leaves the input register always yields a result.
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> out_valid_ff)
      else $error("final byte parsed without a result");

   // Only an ok line carries a command code and argument data.
   a_fail_clears_fields: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_result_ff.status != ST_OK |->
         out_result_ff.command_code == CODE_UNKNOWN &&
         !out_result_ff.has_arguments && out_result_ff.argument_offset == '0)
      else $error("failed line reports command fields");

   a_ok_has_code: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_result_ff.status == ST_OK |->
         out_result_ff.command_code != CODE_UNKNOWN)
      else $error("ok status with unknown command");

   a_tag_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_result_ff.tag_length <= CNT_MAX)
      else $error("tag length beyond line bound");

endmodule
`default_nettype wire

>>> rtl/imap_clc_keyword.sv
`default_nettype none
module imap_clc_keyword (
   input  wire logic                              feed,
   input  wire logic                              start,
   input  wire logic [imap_clc_pkg::NUM_KW-1:0]   mask,
   input  wire logic [imap_clc_pkg::POS_W-1:0]    pos,
   input  wire logic [7:0]                        line_byte,
   output      logic [imap_clc_pkg::NUM_KW-1:0]   mask_next,
   output      logic [imap_clc_pkg::POS_W-1:0]    pos_next,
   output      logic [imap_clc_pkg::CODE_W-1:0]   code
);
   import imap_clc_pkg::*;

   logic [NUM_KW-1:0] mask_base;
   logic [POS_W-1:0]  pos_base;
   logic [7:0]        lower;

   // Fold ASCII upper case onto lower case; everything else compares as is.
   always_comb begin
      lower = line_byte;
      if (line_byte inside {[8'h41:8'h5A]}) begin
         lower = line_byte + CASE_OFFSET;
      end
   end

   always_comb begin
      mask_base = start ? ALL_CANDIDATES : mask;
      pos_base  = start ? '0 : pos;
      mask_next = mask_base;
      pos_next  = pos_base;
      if (feed) begin
         for (int k = 0; k < NUM_KW; k++) begin
            if (pos_base >= KW_LEN[k] || kw_char(KW_TEXT[k], pos_base) != lower) begin
               mask_next[k] = 1'b0;
            end
         end
         pos_next = (pos_base < POS_SAT) ? pos_base + POS_W'(1) : POS_SAT;
      end
   end

   // Lowest surviving keyword whose length equals the word length wins.
   always_comb begin
      code = CODE_UNKNOWN;
      for (int k = NUM_KW - 1; k >= 0; k--) begin
         if (mask_next[k] && KW_LEN[k] == pos_next) begin
            code = CODE_W'(k + 1);
         end
      end
   end

endmodule
`default_nettype wire

>>> rtl/imap_clc_parser.sv
`default_nettype none
module imap_clc_parser (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     step,
   input  wire logic [7:0]               line_byte,
   input  wire logic                     end_of_line,
   output      imap_clc_pkg::result_type result
);
   import imap_clc_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [CNT_W-1:0]  tag_count_ff, tag_count_in;
   logic [CNT_W-1:0]  byte_index_ff, byte_index_in;
   logic [POS_W-1:0]  kw_pos_ff, kw_pos_in;
   logic [NUM_KW-1:0] cand_mask_ff, cand_mask_in;
   logic [CNT_W-1:0]  args_start_ff, args_start_in;
   logic              args_seen_ff, args_seen_in;

   logic              is_space;
   logic              kw_feed;
   logic              kw_start;
   logic [CODE_W-1:0] kw_code;

   assign is_space = (line_byte == SPACE);
   assign kw_start = (phase_ff == PH_GAP1);
   assign kw_feed  = !is_space && (phase_ff == PH_GAP1 || phase_ff == PH_WORD);

   imap_clc_keyword u_keyword (
      .feed      (kw_feed),
      .start     (kw_start),
      .mask      (cand_mask_ff),
      .pos       (kw_pos_ff),
      .line_byte (line_byte),
      .mask_next (cand_mask_in),
      .pos_next  (kw_pos_in),
      .code      (kw_code)
   );

   // Next phase and counters.
   always_comb begin
      phase_in      = phase_ff;
      tag_count_in  = tag_count_ff;
      args_start_in = args_start_ff;
      args_seen_in  = args_seen_ff;
      byte_index_in = sat_inc(byte_index_ff);
      case (phase_ff)
         PH_LEAD: begin
            if (!is_space) begin
               tag_count_in = CNT_W'(1);
               phase_in     = PH_TAG;
            end
         end
         PH_TAG: begin
            if (is_space) phase_in = PH_GAP1;
            else tag_count_in = sat_inc(tag_count_ff);
         end
         PH_GAP1: begin
            if (!is_space) phase_in = PH_WORD;
         end
         PH_WORD: begin
            if (is_space) phase_in = PH_GAP2;
         end
         PH_GAP2: begin
            if (!is_space) begin
               args_seen_in  = 1'b1;
               args_start_in = byte_index_ff;
               phase_in      = PH_ARGS;
            end
         end
         default: begin
            phase_in = PH_ARGS;
         end
      endcase
   end

   // Line summary, taken from the state after this byte.
   always_comb begin
      result = '{status: ST_NO_TAG, command_code: CODE_UNKNOWN,
                 tag_length: tag_count_in, has_arguments: 1'b0,
                 argument_offset: '0};
      if (!(phase_in == PH_LEAD || phase_in == PH_TAG || phase_in == PH_GAP1)) begin
         if (kw_code == CODE_UNKNOWN) begin
            result.status = ST_UNKNOWN;
         end else begin
            result.status          = ST_OK;
            result.command_code    = kw_code;
            result.has_arguments   = args_seen_in;
            result.argument_offset = args_seen_in ? args_start_in : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && end_of_line)) begin
         phase_ff      <= PH_LEAD;
         tag_count_ff  <= '0;
         byte_index_ff <= '0;
         kw_pos_ff     <= '0;
         cand_mask_ff  <= ALL_CANDIDATES;
         args_start_ff <= '0;
         args_seen_ff  <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         tag_count_ff  <= tag_count_in;
         byte_index_ff <= byte_index_in;
         kw_pos_ff     <= kw_pos_in;
         cand_mask_ff  <= cand_mask_in;
         args_start_ff <= args_start_in;
         args_seen_ff  <= args_seen_in;
      end
   end

endmodule
`default_nettype wire
